FILE: design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the block permutation cipher.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int BYTE_W      = 8;
   localparam int KEY_W       = 40;
   localparam int KEY_ENT_W   = 4;
   localparam int CNT_W       = 4;
   localparam int PAD_W       = 4;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_PERM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_COUNT = 2'd2;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   localparam logic [KEY_W-1:0] KEY_RESET = 40'h4682175A93;
   localparam logic [PAD_W-1:0] PAD_RESET = 4'd1;

   typedef struct packed {
      logic [CNT_W-1:0] count;       // bytes to send from the block
      logic             final_blk;   // block ends the stream
      logic             extra_zero;  // a block of zeros follows
   } blk_meta_type;

endpackage

FILE: design/block_permutation_cipher.sv
// ----------------------------------------------------------------------------
// block_permutation_cipher
// Byte stream transposition cipher over blocks of BLOCK_LEN bytes.
//
// req_*: input bytes, req_tlast marks the last byte of a stream.
// rsp_*: reordered bytes, rsp_tlast on the last byte sent for a stream.
// csr_*: register writes (mode, key_perm, pad_count), always ready; write
//    only while the block is idle.
// Bytes are held until a block closes (full, or tlast). The closing byte
// reorders the block combinationally into a registered hand-off buffer;
// the sender loads it once free and sends one byte a cycle while
// rsp_tready is high. Throughput is one byte a cycle each way unless the
// receiver stalls: the sender buffer and the hand-off buffer let the next
// block fill while the previous one drains. A stream ending on a block
// edge in encrypt mode sends a further block of zeros, 2*BLOCK_LEN bytes
// in all, and req_tready drops while the hand-off buffer is still full.
// A stalled receiver holds rsp_* steady; input stops once the hand-off
// buffer cannot be freed. Reset empties all buffers and loads the register
// defaults.
// ----------------------------------------------------------------------------
module block_permutation_cipher
   import bpc_pkg::*;
#(
   parameter int BLOCK_LEN = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,    // [7:0] data_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,    // [7:0] out_byte
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KEY_W-1:0]     csr_data
);

   localparam int FILL_W = $clog2(BLOCK_LEN);

   logic              mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [PAD_W-1:0]  pad_ff;

   logic [BYTE_W-1:0] held_ff [BLOCK_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic [BYTE_W-1:0] perm [BLOCK_LEN];
   blk_meta_type      meta;
   logic              closes, sends;

   logic [BYTE_W-1:0] pend_buf_ff [BLOCK_LEN];
   blk_meta_type      pend_meta_ff;
   logic              pend_valid_ff, pend_valid_in;

   logic [BYTE_W-1:0] out_buf_ff [BLOCK_LEN];
   blk_meta_type      out_meta_ff;
   logic              busy_ff, busy_in;
   logic              zero_ff;
   logic [FILL_W-1:0] idx_ff;

   logic              req_accept, rsp_accept, last_beat, emit_free, emit_load;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCRYPT;
         key_ff  <= KEY_RESET;
         pad_ff  <= PAD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:      mode_ff <= csr_data[0];
            REG_KEY_PERM:  key_ff  <= csr_data;
            REG_PAD_COUNT: pad_ff  <= csr_data[PAD_W-1:0];
            default: ;
         endcase
      end
   end

   // collection
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !pend_valid_ff || emit_load;

   bpc_permute #(
      .BLOCK_LEN (BLOCK_LEN),
      .FILL_W    (FILL_W)
   ) u_permute (
      .held      (held_ff),
      .fill      (fill_ff),
      .data_byte (req_tdata),
      .last      (req_tlast),
      .mode      (mode_ff),
      .key_perm  (key_ff),
      .pad_count (pad_ff),
      .perm      (perm),
      .meta      (meta),
      .closes    (closes),
      .sends     (sends)
   );

   always_comb begin
      fill_in = fill_ff;
      if (req_accept) begin
         fill_in = closes ? '0 : fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         held_ff[fill_ff] <= req_tdata;
      end
   end

   // hand-off buffer
   assign pend_valid_in = (req_accept && sends) || (pend_valid_ff && !emit_load);

   always_ff @(posedge clock) begin
      if (req_accept && sends) begin
         pend_buf_ff  <= perm;
         pend_meta_ff <= meta;
      end
   end

   // sender
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign last_beat  = (CNT_W'(idx_ff) + CNT_W'(1)) == out_meta_ff.count;
   assign emit_free  = !busy_ff || (rsp_accept && last_beat && !out_meta_ff.extra_zero);
   assign emit_load  = emit_free && pend_valid_ff;
   assign busy_in    = emit_load || (busy_ff && !emit_free);

   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_buf_ff  <= pend_buf_ff;
         out_meta_ff <= pend_meta_ff;
         idx_ff      <= '0;
         zero_ff     <= 1'b0;
      end else if (rsp_accept) begin
         if (last_beat) begin
            idx_ff                 <= '0;
            zero_ff                <= 1'b1;
            out_meta_ff.extra_zero <= 1'b0;
         end else begin
            idx_ff <= idx_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         busy_ff       <= busy_in;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = zero_ff ? '0 : out_buf_ff[idx_ff];
   assign rsp_tlast  = out_meta_ff.final_blk && !out_meta_ff.extra_zero && last_beat;

   // checks
   a_pend_kept: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !emit_load |=> pend_valid_ff)
      else $error("hand-off block lost");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> out_meta_ff.count != '0 && CNT_W'(idx_ff) < out_meta_ff.count)
      else $error("send index beyond block");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(fill_ff) < CNT_W'(BLOCK_LEN))
      else $error("fill count beyond block");

   a_zero_block: assert property (@(posedge clock) disable iff (reset)
      busy_ff && zero_ff |-> out_meta_ff.final_blk && !out_meta_ff.extra_zero)
      else $error("zero block outside stream end");

endmodule

FILE: design/bpc_permute.sv
// ----------------------------------------------------------------------------
// bpc_permute
// Builds the closing block from the held bytes and the incoming byte and
// reorders it by the key; works out how many bytes leave and the end flags.
// ----------------------------------------------------------------------------
module bpc_permute
   import bpc_pkg::*;
#(
   parameter int BLOCK_LEN = 10,
   parameter int FILL_W    = $clog2(BLOCK_LEN)
) (
   input  logic [BYTE_W-1:0] held [BLOCK_LEN],
   input  logic [FILL_W-1:0] fill,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              last,
   input  logic              mode,
   input  logic [KEY_W-1:0]  key_perm,
   input  logic [PAD_W-1:0]  pad_count,
   output logic [BYTE_W-1:0] perm [BLOCK_LEN],
   output blk_meta_type      meta,
   output logic              closes,
   output logic              sends
);

   localparam int KEY_EXT_W = KEY_ENT_W * 16;

   logic [KEY_EXT_W-1:0] key_ext;
   logic [BYTE_W-1:0]    store [BLOCK_LEN];
   logic [CNT_W-1:0]     have;
   logic [CNT_W-1:0]     keep;
   logic                 full;

   assign key_ext = {{(KEY_EXT_W - KEY_W){1'b0}}, key_perm};
   assign full    = (fill == FILL_W'(BLOCK_LEN - 1));
   assign have    = CNT_W'(fill) + CNT_W'(1);
   assign keep    = (CNT_W'(pad_count) >= have) ? '0 : have - CNT_W'(pad_count);
   assign closes  = full || last;

   always_comb begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
         if (FILL_W'(i) == fill) begin
            store[i] = data_byte;
         end else if (FILL_W'(i) < fill) begin
            store[i] = held[i];
         end else begin
            store[i] = '0;
         end
      end
   end

   always_comb begin
      for (int a = 0; a < BLOCK_LEN; a++) begin
         perm[a] = '0;
      end
      if (mode == MODE_ENCRYPT) begin
         for (int a = 0; a < BLOCK_LEN; a++) begin
            for (int j = 0; j < BLOCK_LEN; j++) begin
               if (key_ext[KEY_ENT_W*a +: KEY_ENT_W] == KEY_ENT_W'(j + 1)) begin
                  perm[a] = store[j];
               end
            end
         end
      end else begin
         // later key entries overwrite earlier ones
         for (int p = 0; p < BLOCK_LEN; p++) begin
            for (int a = 0; a < BLOCK_LEN; a++) begin
               if (CNT_W'(a) < have &&
                   key_ext[KEY_ENT_W*a +: KEY_ENT_W] == KEY_ENT_W'(p + 1)) begin
                  perm[p] = store[a];
               end
            end
         end
      end
   end

   always_comb begin
      meta.count      = CNT_W'(BLOCK_LEN);
      meta.final_blk  = last;
      meta.extra_zero = 1'b0;
      sends           = closes;
      if (mode == MODE_ENCRYPT) begin
         meta.extra_zero = last && full;
      end else if (last) begin
         meta.count = keep;
         sends      = (keep != '0);
      end
   end

endmodule

FILE: sim/tb_block_permutation_cipher.sv
// ----------------------------------------------------------------------------
// tb_block_permutation_cipher
// Self-checking bench for the block permutation cipher. A scoreboard keeps
// its own copy of the registers and the block store and predicts every
// reordered word from the words accepted on req_*. Directed streams cover
// padding, trimming and odd keys; random streams follow under changing
// settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_block_permutation_cipher
   import bpc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_LEN    = 10;
   localparam int RANDOM_ITEMS = 436;
   localparam int SETTLE       = 30;
   localparam int DRAIN        = 60;
   localparam int LIMIT        = 2000000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } cipher_word_type;

   class cipher_board_type;
      logic              mode_q;
      logic [KEY_W-1:0]  key_q;
      logic [PAD_W-1:0]  pad_q;
      logic [BYTE_W-1:0] store_q [BLOCK_LEN];
      int                fill_q;
      cipher_word_type   due_bytes [$];

      function new();
         mode_q = MODE_ENCRYPT;
         key_q  = KEY_RESET;
         pad_q  = PAD_RESET;
         fill_q = 0;
         foreach (store_q[i]) store_q[i] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
         case (idx)
            REG_MODE:      mode_q = data[0];
            REG_KEY_PERM:  key_q  = data;
            REG_PAD_COUNT: pad_q  = data[PAD_W-1:0];
            default: ;
         endcase
      endfunction

      // zero-based target of key entry a, -1 when the entry names nothing
      function int key_target(int a);
         int k;
         k = int'(key_q[KEY_ENT_W*a +: KEY_ENT_W]);
         if (k < 1 || k > BLOCK_LEN) return -1;
         return k - 1;
      endfunction

      function void permute_block(int have, int count, bit final_blk);
         logic [BYTE_W-1:0] perm [BLOCK_LEN];
         cipher_word_type   w;
         int                p;
         foreach (perm[i]) perm[i] = '0;
         if (mode_q == MODE_ENCRYPT) begin
            for (int a = 0; a < BLOCK_LEN; a++) begin
               p = key_target(a);
               if (p >= 0) perm[a] = store_q[p];
            end
         end else begin
            for (int a = 0; a < have; a++) begin
               p = key_target(a);
               if (p >= 0) perm[p] = store_q[a];
            end
         end
         for (int a = 0; a < count; a++) begin
            w.data = perm[a];
            w.last = final_blk && (a + 1 == count);
            due_bytes.push_back(w);
         end
      endfunction

      function void note_word(logic [BYTE_W-1:0] data, logic last);
         int keep;
         if (fill_q >= BLOCK_LEN) fill_q = 0;
         store_q[fill_q] = data;
         fill_q++;
         if (mode_q == MODE_ENCRYPT) begin
            if (fill_q == BLOCK_LEN) begin
               permute_block(BLOCK_LEN, BLOCK_LEN, 1'b0);
               fill_q = 0;
            end
            if (last) begin
               for (int i = fill_q; i < BLOCK_LEN; i++) store_q[i] = '0;
               permute_block(BLOCK_LEN, BLOCK_LEN, 1'b1);
               fill_q = 0;
            end
         end else begin
            if (last) begin
               keep = (int'(pad_q) >= fill_q) ? 0 : fill_q - int'(pad_q);
               permute_block(fill_q, keep, 1'b1);
               fill_q = 0;
            end else if (fill_q == BLOCK_LEN) begin
               permute_block(BLOCK_LEN, BLOCK_LEN, 1'b0);
               fill_q = 0;
            end
         end
      endfunction

      function bit check_word(logic [BYTE_W-1:0] got_data, logic got_last,
                              output string why);
         cipher_word_type w;
         why = "";
         if (due_bytes.size() == 0) begin
            why = $sformatf("unexpected word %02h last %0b", got_data, got_last);
            return 1'b1;
         end
         w = due_bytes.pop_front();
         if (got_data !== w.data)
            why = {why, $sformatf(" out_byte %02h want %02h", got_data, w.data)};
         if (got_last !== w.last)
            why = {why, $sformatf(" last_out %0b want %0b", got_last, w.last)};
         return why != "";
      endfunction

      function int pending();
         return due_bytes.size();
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [BYTE_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [KEY_W-1:0]     csr_data   = '0;

   cipher_board_type board;
   int unsigned cycle_count = 0;
   int          mismatches  = 0;
   int          words_sent  = 0;
   int          hold_left   = 0;
   bit          no_idle     = 1'b0;
   string       rsp_why;

   block_permutation_cipher #(.BLOCK_LEN(BLOCK_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch at cycle %0d:%s", cycle_count, msg);
      mismatches++;
   endtask

   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: checks each word taken, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (board.check_word(rsp_tdata, rsp_tlast, rsp_why)) report(rsp_why);
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            rsp_tready <= 1'b0;
            hold_left = idle_len() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [BYTE_W-1:0] data, input logic last);
      int gap;
      gap = (!no_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(data, last);
      words_sent++;
   endtask

   task automatic send_run(input int n, input bit close);
      for (int i = 0; i < n; i++)
         send_word(BYTE_W'($urandom_range(0, 255)), close && (i == n - 1));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.write_reg(idx, data);
   endtask

   // settings change only once all results are out and the block has settled
   task automatic load_settings(input logic mode, input logic [KEY_W-1:0] key,
                                input logic [PAD_W-1:0] pad);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      write_csr(REG_MODE, KEY_W'(mode));
      write_csr(REG_KEY_PERM, key);
      write_csr(REG_PAD_COUNT, KEY_W'(pad));
   endtask

   function automatic logic [KEY_W-1:0] shuffled_key();
      int               slot [BLOCK_LEN];
      int               j;
      int               t;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < BLOCK_LEN; i++) slot[i] = i + 1;
      for (int i = BLOCK_LEN - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = slot[i];
         slot[i] = slot[j];
         slot[j] = t;
      end
      k = '0;
      for (int i = 0; i < BLOCK_LEN; i++) k[KEY_ENT_W*i +: KEY_ENT_W] = slot[i][3:0];
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return KEY_W'({$urandom, $urandom});
         default: return shuffled_key();
      endcase
   endfunction

   function automatic logic [PAD_W-1:0] pick_pad();
      if ($urandom_range(0, 9) < 7) return PAD_W'($urandom_range(1, 10));
      return PAD_W'($urandom_range(0, 15));
   endfunction

   initial begin
      int phase_len;
      int phase_sent;
      int n;
      int r;
      bit close;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encrypt with the reset key, short stream padded with zeros
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hA5, 1'b1);

      // decrypt, short final block, nothing trimmed
      load_settings(MODE_DECRYPT, KEY_RESET, 4'd0);
      send_run(4, 1'b1);

      // trim longer than the final block: no output
      load_settings(MODE_DECRYPT, KEY_RESET, 4'd10);
      send_run(2, 1'b1);

      // repeated, zero and out-of-range key entries
      load_settings(MODE_ENCRYPT, 40'hB2C1A70F33, 4'd1);
      send_run(1, 1'b1);
      load_settings(MODE_DECRYPT, 40'hB2C1A70F33, 4'd1);
      send_run(4, 1'b1);

      // mode switched with half a block held; stream closes on a block edge
      load_settings(MODE_DECRYPT, KEY_RESET, 4'd15);
      send_run(5, 1'b0);
      load_settings(MODE_ENCRYPT, KEY_RESET, 4'd15);
      send_run(5, 1'b1);

      n = words_sent + RANDOM_ITEMS;
      while (words_sent < n) begin
         load_settings(logic'($urandom_range(0, 1)), pick_key(), pick_pad());
         no_idle    = ($urandom_range(0, 4) == 0);
         phase_len  = $urandom_range(25, 50);
         phase_sent = 0;
         while (phase_sent < phase_len && words_sent < n) begin
            r = $urandom_range(0, 99);
            case (1'b1)
               (r < 15): begin
                  r = 10 * $urandom_range(1, 3);
               end
               (r < 85): begin
                  r = $urandom_range(1, 25);
               end
               default: begin
                  r = $urandom_range(26, 45);
               end
            endcase
            if (r > n - words_sent) r = n - words_sent;
            close = ($urandom_range(0, 9) != 0);
            send_run(r, close);
            phase_sent += r;
         end
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
